>>> src/wts_pkg.sv
// ----------------------------------------------------------------------------
// Waypoint target selector package
// Shared widths, codes and the decoded operation passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package wts_pkg;

    localparam int IDX_W     = 10;
    localparam int PLEN_W    = IDX_W + 1;
    localparam int POS_W     = 32;
    localparam int MODE_W    = 8;
    localparam int DEV_W     = 24;
    localparam int SCALE_W   = 16;
    localparam int SCALE_FRAC = 8;
    localparam int DEVQ_W    = 32;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 2;
    localparam int WP_W      = 2 * POS_W + MODE_W;
    localparam int Q_DEPTH   = 2;
    localparam int Q_AW      = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [DEV_W-1:0]   TARGET_DEV_RST = 24'd32768;
    localparam logic [DEV_W-1:0]   FINAL_DEV_RST  = 24'd6554;
    localparam logic [SCALE_W-1:0] FAIL_SCALE_RST = 16'd512;
    localparam logic [MODE_W-1:0]  STOP_CODE_RST  = 8'd0;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_TICK = 2'd1,
        CMD_SET  = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_DEV = 2'd0,
        CFG_FINAL_DEV  = 2'd1,
        CFG_FAIL_SCALE = 2'd2,
        CFG_STOP_CODE  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [DEV_W-1:0]   target_dev;
        logic [DEV_W-1:0]   final_dev;
        logic [SCALE_W-1:0] fail_scale;
        logic [MODE_W-1:0]  stop_code;
    } t_cfg;

    typedef enum logic [1:0] {
        K_LOAD = 2'd0,
        K_SET  = 2'd1,
        K_TICK = 2'd2
    } t_kind;

    // idx is the slot for a load, the clamped target for a set and the
    // last path index for a tick.
    typedef struct packed {
        t_kind              kind;
        logic [IDX_W-1:0]   idx;
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic [MODE_W-1:0]  mode;
        logic [DEVQ_W-1:0]  dev;
    } t_op;

    typedef struct packed {
        logic push;
        logic full;
    } t_q_in;

endpackage

`default_nettype wire

>>> src/wts_if.sv
// ----------------------------------------------------------------------------
// Waypoint target selector channels
// Request channel (commands and poses) and result channel (selected target).
// ----------------------------------------------------------------------------
`default_nettype none

interface wts_req_if import wts_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [1:0]               cmd;
    logic [IDX_W-1:0]         wp_index;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic [MODE_W-1:0]        wp_mode;
    logic                     last_entry;
    logic                     plan_ok;

    modport source (output valid, cmd, wp_index, pos_x, pos_y, wp_mode, last_entry,
                    plan_ok, input ready);
    modport sink   (input valid, cmd, wp_index, pos_x, pos_y, wp_mode, last_entry,
                    plan_ok, output ready);
endinterface

interface wts_res_if import wts_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [IDX_W-1:0]         target_idx;
    logic signed [POS_W-1:0]  target_x;
    logic signed [POS_W-1:0]  target_y;
    logic                     reached;

    modport source (output valid, target_idx, target_x, target_y, reached,
                    input ready);
    modport sink   (input valid, target_idx, target_x, target_y, reached,
                    output ready);
endinterface

`default_nettype wire

>>> src/wts_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> src/wts_front.sv
// ----------------------------------------------------------------------------
// Waypoint target selector front end
// Accepts requests, tracks the path length and turns requests into operations.
// ----------------------------------------------------------------------------
`default_nettype none

module wts_front import wts_pkg::*; #(
    parameter int PATH_DEPTH = 1024
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    wts_req_if.sink    i_req,
    input  wire logic  i_q_full,
    output      t_q_in o_q_ctl,
    output      t_op   o_op
);

    logic [PLEN_W-1:0]         r_path_len;
    logic [PLEN_W-1:0]         n_path_len;
    logic [PLEN_W-1:0]         len_m1;
    logic [DEV_W+SCALE_W-1:0]  scaled;
    logic                      accept;
    logic                      keep;
    logic                      in_range;

    assign accept   = i_req.valid && !i_q_full;
    assign len_m1   = r_path_len - PLEN_W'(1);
    assign in_range = 32'(i_req.wp_index) < 32'(PATH_DEPTH);
    assign scaled   = i_cfg.target_dev * i_cfg.fail_scale;

    always_comb begin
        keep       = 1'b0;
        n_path_len = r_path_len;
        o_op.kind  = K_TICK;
        o_op.idx   = i_req.wp_index;
        o_op.x     = i_req.pos_x;
        o_op.y     = i_req.pos_y;
        o_op.mode  = i_req.wp_mode;
        o_op.dev   = i_req.plan_ok ? DEVQ_W'(i_cfg.target_dev)
                                   : scaled[SCALE_FRAC +: DEVQ_W];
        case (i_req.cmd)
            CMD_LOAD: begin
                o_op.kind = K_LOAD;
                keep      = in_range;
                if (in_range && i_req.last_entry) begin
                    n_path_len = {1'b0, i_req.wp_index} + PLEN_W'(1);
                end
            end
            CMD_SET: begin
                o_op.kind = K_SET;
                keep      = 1'b1;
                if (r_path_len == '0) begin
                    o_op.idx = '0;
                end else if ({1'b0, i_req.wp_index} > len_m1) begin
                    o_op.idx = len_m1[IDX_W-1:0];
                end
            end
            CMD_TICK: begin
                // A tick on an empty path yields nothing.
                o_op.kind = K_TICK;
                o_op.idx  = len_m1[IDX_W-1:0];
                keep      = (r_path_len != '0);
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_path_len <= '0;
        end else if (accept) begin
            r_path_len <= n_path_len;
        end
    end

    assign i_req.ready  = !i_q_full;
    assign o_q_ctl.push = accept && keep;
    assign o_q_ctl.full = i_q_full;

endmodule

`default_nettype wire

>>> src/wts_queue.sv
// ----------------------------------------------------------------------------
// Waypoint target selector operation queue
// Short FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module wts_queue import wts_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_q_in i_ctl,
    input  wire t_op   i_op,
    input  wire logic  i_pop,
    output      logic  o_full,
    output      logic  o_empty,
    output      t_op   o_head
);

    t_op                r_mem [Q_DEPTH];
    logic [Q_AW-1:0]    r_wp;
    logic [Q_AW-1:0]    r_rp;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_ctl.push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wp + Q_AW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rp + Q_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + Q_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - Q_CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> src/wts_back.sv
// ----------------------------------------------------------------------------
// Waypoint target selector back end
// Owns the waypoint table and the target index and walks the path on a tick.
// ----------------------------------------------------------------------------
`default_nettype none

module wts_back import wts_pkg::*; #(
    parameter int PATH_DEPTH = 1024
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_q_empty,
    input  wire t_op  i_head,
    output      logic o_pop,
    wts_res_if.source o_res
);

    localparam int AW = $clog2(PATH_DEPTH);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_RD   = 8'b0000_0010,
        S_DIFF = 8'b0000_0100,
        S_SQ   = 8'b0000_1000,
        S_SUM  = 8'b0001_0000,
        S_DEC  = 8'b0010_0000,
        S_ORD  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

    t_state                    r_state;
    t_state                    n_state;
    logic [IDX_W-1:0]          r_cur;
    logic [IDX_W-1:0]          n_cur;
    logic [IDX_W-1:0]          r_end;
    logic [POS_W-1:0]          r_px;
    logic [POS_W-1:0]          r_py;
    logic [2*DEVQ_W-1:0]       r_dev2;
    logic [2*DEV_W-1:0]        r_fin2;
    logic [POS_W-1:0]          r_dx;
    logic [POS_W-1:0]          r_dy;
    logic [MODE_W-1:0]         r_mode;
    logic [2*POS_W-1:0]        r_sqx;
    logic [2*POS_W-1:0]        r_sqy;
    logic [2*POS_W:0]          r_sum;
    logic                      r_reached;
    logic                      r_oreached;
    logic                      r_ovalid;
    logic [IDX_W-1:0]          r_oidx;
    logic [POS_W-1:0]          r_ox;
    logic [POS_W-1:0]          r_oy;

    logic [WP_W-1:0]           rdata;
    logic [POS_W-1:0]          rd_x;
    logic [POS_W-1:0]          rd_y;
    logic [MODE_W-1:0]         rd_mode;
    logic [AW+IDX_W-1:0]       raddr_wide;
    logic [AW+IDX_W-1:0]       waddr_wide;
    logic                      ram_we;
    logic [POS_W:0]            diff_x;
    logic [POS_W:0]            diff_y;
    logic [POS_W:0]            neg_x;
    logic [POS_W:0]            neg_y;
    logic [2*DEVQ_W-1:0]       dev_sq;
    logic [2*DEV_W-1:0]        fin_sq;
    logic                      stop_walk;
    logic                      reached;
    logic                      out_load;

    assign o_pop      = (r_state == S_IDLE) && !i_q_empty;
    assign ram_we     = o_pop && (i_head.kind == K_LOAD);
    assign raddr_wide = {{AW{1'b0}}, r_cur};
    assign waddr_wide = {{AW{1'b0}}, i_head.idx};

    wts_ram #(
        .WIDTH (WP_W),
        .DEPTH (PATH_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr_wide[AW-1:0]),
        .i_wdata ({i_head.x, i_head.y, i_head.mode}),
        .i_raddr (raddr_wide[AW-1:0]),
        .o_rdata (rdata)
    );

    assign rd_x    = rdata[WP_W-1 -: POS_W];
    assign rd_y    = rdata[MODE_W +: POS_W];
    assign rd_mode = rdata[MODE_W-1:0];

    // Signed differences in one extra bit; the magnitude always fits POS_W bits.
    assign diff_x = {rd_x[POS_W-1], rd_x} - {r_px[POS_W-1], r_px};
    assign diff_y = {rd_y[POS_W-1], rd_y} - {r_py[POS_W-1], r_py};
    assign neg_x  = '0 - diff_x;
    assign neg_y  = '0 - diff_y;

    assign dev_sq = i_head.dev * i_head.dev;
    assign fin_sq = i_cfg.final_dev * i_cfg.final_dev;

    assign stop_walk = (r_sum >= {1'b0, r_dev2}) || (r_cur >= r_end)
                       || (r_mode == i_cfg.stop_code);
    assign reached   = (r_sum <= (2*POS_W+1)'(r_fin2));
    assign out_load  = (r_state == S_OUT) && (!r_ovalid || o_res.ready);

    always_comb begin
        n_state = r_state;
        n_cur   = r_cur;
        case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    case (i_head.kind)
                        K_SET: begin
                            n_cur = i_head.idx;
                        end
                        K_TICK: begin
                            n_cur   = (r_cur > i_head.idx) ? i_head.idx : r_cur;
                            n_state = S_RD;
                        end
                        default: begin
                            n_cur = r_cur;
                        end
                    endcase
                end
            end
            S_RD:   n_state = S_DIFF;
            S_DIFF: n_state = S_SQ;
            S_SQ:   n_state = S_SUM;
            S_SUM:  n_state = S_DEC;
            S_DEC: begin
                if (!stop_walk) begin
                    n_cur   = r_cur + IDX_W'(1);
                    n_state = S_RD;
                end else begin
                    if (reached && (r_cur < r_end)) begin
                        n_cur = r_cur + IDX_W'(1);
                    end
                    n_state = S_ORD;
                end
            end
            S_ORD:  n_state = S_OUT;
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cur    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && (i_head.kind == K_TICK)) begin
            r_px   <= i_head.x;
            r_py   <= i_head.y;
            r_end  <= i_head.idx;
            r_dev2 <= dev_sq;
            r_fin2 <= fin_sq;
        end
        if (r_state == S_DIFF) begin
            r_dx   <= diff_x[POS_W] ? neg_x[POS_W-1:0] : diff_x[POS_W-1:0];
            r_dy   <= diff_y[POS_W] ? neg_y[POS_W-1:0] : diff_y[POS_W-1:0];
            r_mode <= rd_mode;
        end
        if (r_state == S_SQ) begin
            r_sqx <= r_dx * r_dx;
            r_sqy <= r_dy * r_dy;
        end
        if (r_state == S_SUM) begin
            r_sum <= {1'b0, r_sqx} + {1'b0, r_sqy};
        end
        if (r_state == S_DEC) begin
            r_reached <= reached;
        end
        if (out_load) begin
            r_oidx <= r_cur;
            r_ox   <= rd_x;
            r_oy   <= rd_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_oreached <= r_reached;
        end
    end

    assign o_res.valid      = r_ovalid;
    assign o_res.target_idx = r_oidx;
    assign o_res.target_x   = r_ox;
    assign o_res.target_y   = r_oy;
    assign o_res.reached    = r_oreached;

endmodule

`default_nettype wire

>>> src/waypoint_target_selector.sv
// ----------------------------------------------------------------------------
// Waypoint target selector
// Keeps a path of waypoints and picks the look-ahead target on each tick.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Carries
//   i_req     in         load waypoint, tick with robot pose, set target index
//   o_res     out        target index, target position, reached flag
//   i_cfg_*   in         register writes (target_dev, final_dev, fail_scale,
//                        stop_code)
//
// In the back end a tick walks the path one waypoint at a time; each step
// is one table read, a subtract, two 32x32 squares and a 65-bit add and
// compare. Loads and sets are applied in the back end's idle state. Reset
// is synchronous and clears the path length, the target index, the queue
// and the result register; table contents stay undefined until loaded. The
// front end keeps accepting requests into a two-entry queue while the back
// end walks the path or a result waits to be taken, so each side stalls
// only on its own neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module waypoint_target_selector import wts_pkg::*; #(
    parameter int PATH_DEPTH = 1024
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    wts_req_if.sink                   i_req,
    wts_res_if.source                 o_res,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    // Configuration registers. The user must change them only while the block is
    // idle; the block does not enforce this, and both halves read them directly.
    t_cfg  r_cfg;

    t_q_in q_ctl;
    t_op   q_in_op;
    t_op   q_head;
    logic  q_full;
    logic  q_empty;
    logic  q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_dev <= TARGET_DEV_RST;
            r_cfg.final_dev  <= FINAL_DEV_RST;
            r_cfg.fail_scale <= FAIL_SCALE_RST;
            r_cfg.stop_code  <= STOP_CODE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TARGET_DEV: r_cfg.target_dev <= i_cfg_data[DEV_W-1:0];
                CFG_FINAL_DEV:  r_cfg.final_dev  <= i_cfg_data[DEV_W-1:0];
                CFG_FAIL_SCALE: r_cfg.fail_scale <= i_cfg_data[SCALE_W-1:0];
                CFG_STOP_CODE:  r_cfg.stop_code  <= i_cfg_data[MODE_W-1:0];
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    // The front end decodes each request, drops the ones that have no
    // effect, and precomputes the deviation and the clamped indexes.
    wts_front #(
        .PATH_DEPTH (PATH_DEPTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_req    (i_req),
        .i_q_full (q_full),
        .o_q_ctl  (q_ctl),
        .o_op     (q_in_op)
    );

    wts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (q_ctl),
        .i_op    (q_in_op),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // The back end applies operations in order: it writes the table, moves
    // the target, and on a tick walks the path and registers the result.
    wts_back #(
        .PATH_DEPTH (PATH_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .i_head    (q_head),
        .o_pop     (q_pop),
        .o_res     (o_res)
    );

endmodule

`default_nettype wire

>>> src/wts_checker.sv
// ----------------------------------------------------------------------------
// Waypoint target selector checker
// Port-level assertions on the request and result channels.
// ----------------------------------------------------------------------------
`default_nettype none

module wts_checker import wts_pkg::*; (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_req_valid,
    input wire logic             i_req_ready,
    input wire logic             i_res_valid,
    input wire logic             i_res_ready,
    input wire logic [IDX_W-1:0] i_res_idx,
    input wire logic [POS_W-1:0] i_res_x,
    input wire logic [POS_W-1:0] i_res_y,
    input wire logic             i_res_reached
);

    // Reset empties the result register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

    // The request side only backs up after a request went into the queue.
    a_ready_falls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(i_req_ready) && $past(i_rst_n) |-> $past(i_req_valid))
        else $error("request ready dropped without a request");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result withdrawn while stalled");

    a_res_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> $stable(i_res_idx) && $stable(i_res_x)
            && $stable(i_res_y) && $stable(i_res_reached))
        else $error("result changed while stalled");

endmodule

bind waypoint_target_selector wts_checker u_wts_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_res_idx     (o_res.target_idx),
    .i_res_x       (o_res.target_x),
    .i_res_y       (o_res.target_y),
    .i_res_reached (o_res.reached)
);

`default_nettype wire
